/* rtl/core/lkvc_pkg.sv */
package lkvc_pkg;

	localparam int KEY_W        = 32;
	localparam int VALUE_W      = 32;
	localparam int CAP_W        = 4;
	localparam int DEF_ENTRIES  = 8;
	localparam int DEF_KEY_BITS = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

	typedef enum logic {
		MODE_GET = 1'b0,
		MODE_PUT = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                     mode;
		logic [KEY_W-1:0]          key;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                      hit;
		logic signed [VALUE_W-1:0] read_value;
		logic [KEY_W-1:0]          recent_key;
		logic                      recent_valid;
	} res_t;

endpackage

/* rtl/core/lkvc_store.sv */
module lkvc_store #(
	parameter int ENTRIES  = 8,
	parameter int KEY_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lkvc_pkg::CAP_W-1:0]  capacity,
	input  logic                        step,
	input  lkvc_pkg::req_t              req,
	output lkvc_pkg::res_t              res
);
	import lkvc_pkg::*;

	localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW = $clog2(ENTRIES + 1);

	logic [KEY_BITS-1:0] key_q   [ENTRIES];
	logic [VALUE_W-1:0]  value_q [ENTRIES];
	logic [RW-1:0]       rank_q  [ENTRIES];
	logic [RW-1:0]       rank_n  [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	logic [ENTRIES-1:0]  valid_n;
	logic [OW-1:0]       occ_q;
	logic [OW-1:0]       occ_n;
	logic [KEY_BITS-1:0] recent_q;
	logic [KEY_BITS-1:0] recent_n;

	logic [KEY_BITS-1:0] key_in;
	logic                is_put;
	logic [ENTRIES-1:0]  match;
	logic                found;
	logic [VALUE_W-1:0]  rd_val;
	logic [RW-1:0]       hit_rank;
	logic [OW-1:0]       cap_eff;
	logic                full;
	logic [ENTRIES-1:0]  evict;
	logic [ENTRIES-1:0]  free;
	logic [ENTRIES-1:0]  slot_oh;
	logic [ENTRIES-1:0]  wr_key;
	logic [ENTRIES-1:0]  wr_val;

	assign key_in = KEY_BITS'(req.key);
	assign is_put = (req.mode == MODE_PUT);

	always_comb begin
		rd_val   = '0;
		hit_rank = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key_in);
			if (match[i]) begin
				rd_val   = rd_val | value_q[i];
				hit_rank = hit_rank | rank_q[i];
			end
		end
	end

	assign found = |match;

	always_comb begin
		if (capacity == '0) begin
			cap_eff = OW'(1);
		end else if (32'(capacity) > 32'(ENTRIES)) begin
			cap_eff = OW'(ENTRIES);
		end else begin
			cap_eff = OW'(capacity);
		end
	end

	assign full = (occ_q >= cap_eff);

	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			evict[i]   = full && valid_q[i] && (OW'(rank_q[i]) >= (cap_eff - OW'(1)));
			free[i]    = !(valid_q[i] && !evict[i]);
			slot_oh[i] = free[i] && !seen;
			seen       = seen | free[i];
		end
	end

	always_comb begin
		valid_n  = valid_q;
		occ_n    = occ_q;
		recent_n = recent_q;
		wr_key   = '0;
		wr_val   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			rank_n[i] = rank_q[i];
		end
		if (found) begin
			recent_n = key_in;
			wr_val   = is_put ? match : '0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (match[i]) begin
					rank_n[i] = '0;
				end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
					rank_n[i] = rank_q[i] + RW'(1);
				end
			end
		end else if (is_put) begin
			recent_n = key_in;
			wr_key   = slot_oh;
			wr_val   = slot_oh;
			occ_n    = full ? cap_eff : (occ_q + OW'(1));
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot_oh[i]) begin
					valid_n[i] = 1'b1;
					rank_n[i]  = '0;
				end else if (free[i]) begin
					valid_n[i] = 1'b0;
					rank_n[i]  = '0;
				end else begin
					rank_n[i] = rank_q[i] + RW'(1);
				end
			end
		end
	end

	assign res.hit          = found;
	assign res.read_value   = (found && !is_put) ? signed'(rd_val) : '0;
	assign res.recent_key   = KEY_W'(recent_n);
	assign res.recent_valid = (occ_n != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			occ_q    <= '0;
			recent_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (step) begin
			valid_q  <= valid_n;
			occ_q    <= occ_n;
			recent_q <= recent_n;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_n[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (step && wr_key[i]) begin
				key_q[i] <= key_in;
			end
			if (step && wr_val[i]) begin
				value_q[i] <= req.value;
			end
		end
	end

`ifndef SYNTHESIS
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("key present in more than one entry");

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy disagrees with valid entries");

	a_put_fills: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_put |=> occ_q != '0)
		else $error("cache empty after a put");

	a_get_keeps_occ: assert property (@(posedge clk) disable iff (!arst_n)
		step && !is_put |=> occ_q == $past(occ_q))
		else $error("get changed occupancy");
`endif

endmodule

/* rtl/core/lru_key_value_cache_core.sv */
// Channel  Handshake             Payload
// in       in_valid / in_ready   mode, lookup_key, write_value
// out      out_valid / out_ready hit, read_value, recent_key, recent_valid
// cfg      cfg_wr_en             cfg_wr_data (capacity)
//
// One item per cycle while out_ready keeps up; items are held in s1, results in res_q.
// Lookup, recency update and insert/evict are computed together in lkvc_store.
// Reset clears all entries and sets capacity to 8; no clearing pass is needed.
// A stalled output holds its item while the input stage holds the next one.
module lru_key_value_cache_core #(
	parameter int ENTRIES  = lkvc_pkg::DEF_ENTRIES,
	parameter int KEY_BITS = lkvc_pkg::DEF_KEY_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                mode,
	input  logic [lkvc_pkg::KEY_W-1:0]          lookup_key,
	input  logic signed [lkvc_pkg::VALUE_W-1:0] write_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic signed [lkvc_pkg::VALUE_W-1:0] read_value,
	output logic [lkvc_pkg::KEY_W-1:0]          recent_key,
	output logic                                recent_valid,
	input  logic                                cfg_wr_en,
	input  logic [lkvc_pkg::CAP_W-1:0]          cfg_wr_data
);
	import lkvc_pkg::*;

	logic [CAP_W-1:0]          cap_q;
	logic                      valid_s1;
	logic                      mode_s1;
	logic [KEY_W-1:0]          key_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic                      out_valid_q;
	res_t                      res_q;

	logic                      out_free;
	logic                      go;
	req_t                      req;
	res_t                      res;

	assign out_free = !out_valid_q || out_ready;
	assign go       = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode;
			key_s1   <= lookup_key;
			value_s1 <= write_value;
		end
		if (go) begin
			res_q <= res;
		end
	end

	assign req.mode  = mode_t'(mode_s1);
	assign req.key   = key_s1;
	assign req.value = value_s1;

	lkvc_store #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (cap_q),
		.step     (go),
		.req      (req),
		.res      (res)
	);

	assign out_valid    = out_valid_q;
	assign hit          = res_q.hit;
	assign read_value   = res_q.read_value;
	assign recent_key   = res_q.recent_key;
	assign recent_valid = res_q.recent_valid;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import lkvc_pkg::*;

	localparam int ENTRIES   = DEF_ENTRIES;
	localparam int LIMIT     = 200000;
	localparam int LONG_HOLD = 400;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      in_valid     = 1'b0;
	logic                      in_ready;
	mode_t                     mode         = MODE_GET;
	logic [KEY_W-1:0]          lookup_key   = '0;
	logic signed [VALUE_W-1:0] write_value  = '0;
	logic                      out_valid;
	logic                      out_ready    = 1'b0;
	logic                      hit;
	logic signed [VALUE_W-1:0] read_value;
	logic [KEY_W-1:0]          recent_key;
	logic                      recent_valid;
	logic                      cfg_wr_en    = 1'b0;
	logic [CAP_W-1:0]          cfg_wr_data  = '0;

	logic [KEY_W-1:0]          slot_key   [ENTRIES];
	logic signed [VALUE_W-1:0] slot_value [ENTRIES];
	logic                      slot_used  [ENTRIES];
	int                        slot_age   [ENTRIES];
	int                        used_count;
	logic [CAP_W-1:0]          capacity_reg;

	res_t             cache_results_q[$];
	logic [KEY_W-1:0] key_pool[16];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int hits_seen     = 0;
	int errors        = 0;
	int cycles        = 0;
	int hold_left     = 0;
	bit hold_toggle   = 1'b0;
	bit hold_seen     = 1'b0;

	lru_key_value_cache_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.read_value  (read_value),
		.recent_key  (recent_key),
		.recent_valid(recent_valid),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int effective_capacity();
		if (int'(capacity_reg) == 0)
			return 1;
		if (int'(capacity_reg) > ENTRIES)
			return ENTRIES;
		return int'(capacity_reg);
	endfunction

	function automatic res_t lru_access(mode_t m, logic [KEY_W-1:0] k,
			logic signed [VALUE_W-1:0] v);
		int   found;
		int   slot;
		int   cap;
		int   old_age;
		res_t r;
		found = -1;
		slot  = -1;
		r     = '0;
		for (int i = 0; i < ENTRIES; i++)
			if (found < 0 && slot_used[i] && slot_key[i] == k)
				found = i;
		if (found >= 0) begin
			r.hit = 1'b1;
			if (m == MODE_PUT)
				slot_value[found] = v;
			else
				r.read_value = slot_value[found];
			old_age = slot_age[found];
			for (int i = 0; i < ENTRIES; i++)
				if (slot_used[i] && slot_age[i] < old_age)
					slot_age[i]++;
			slot_age[found] = 0;
		end else if (m == MODE_PUT) begin
			cap = effective_capacity();
			if (used_count >= cap) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_used[i] && slot_age[i] >= cap - 1) begin
						slot_used[i] = 1'b0;
						slot_age[i]  = 0;
						used_count--;
					end
				end
			end
			for (int i = 0; i < ENTRIES; i++)
				if (slot_used[i])
					slot_age[i]++;
			for (int i = 0; i < ENTRIES; i++)
				if (slot < 0 && !slot_used[i])
					slot = i;
			if (slot >= 0) begin
				slot_key[slot]   = k;
				slot_value[slot] = v;
				slot_used[slot]  = 1'b1;
				slot_age[slot]   = 0;
				used_count++;
			end
		end
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (slot_used[i] && slot_age[i] == 0)
				r.recent_key = slot_key[i];
		r.recent_valid = (used_count > 0);
		return r;
	endfunction

	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (cache_results_q.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: hit=%0b read=%0d key=%h valid=%0b",
					$time, hit, read_value, recent_key, recent_valid);
			end else begin
				exp_r = cache_results_q.pop_front();
				if (exp_r.hit)
					hits_seen++;
				if (hit !== exp_r.hit) begin
					errors++;
					$display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, hit);
				end
				if (read_value !== exp_r.read_value) begin
					errors++;
					$display("%0t: read_value expected %0d actual %0d",
						$time, exp_r.read_value, read_value);
				end
				if (recent_key !== exp_r.recent_key) begin
					errors++;
					$display("%0t: recent_key expected %h actual %h",
						$time, exp_r.recent_key, recent_key);
				end
				if (recent_valid !== exp_r.recent_valid) begin
					errors++;
					$display("%0t: recent_valid expected %0b actual %0b",
						$time, exp_r.recent_valid, recent_valid);
				end
			end
		end
	end

	task automatic send_item(input mode_t m, input logic [KEY_W-1:0] k,
			input logic signed [VALUE_W-1:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		lookup_key  <= k;
		write_value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		cache_results_q.push_back(lru_access(m, k, v));
		items_sent++;
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		in_valid <= 1'b0;
		while (cache_results_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		capacity_reg = cap;
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic test_basic_ops();
		send_item(MODE_GET, 32'h0000_0000, 32'sd0);
		send_item(MODE_PUT, 32'h0000_0000, 32'sh8000_0000);
		send_item(MODE_PUT, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
		send_item(MODE_GET, 32'h0000_0000, 32'sh1234_5678);
		send_item(MODE_PUT, 32'hFFFF_FFFF, -32'sd1);
		send_item(MODE_GET, 32'h1234_5678, 32'sd0);
		send_item(MODE_GET, 32'hFFFF_FFFF, 32'sd0);
	endtask

	task automatic test_eviction();
		set_capacity(4'd2);
		send_item(MODE_PUT, 32'h0000_00A5, 32'sd5);
		send_item(MODE_GET, 32'h0000_0000, 32'sd0);
		set_capacity(4'd0);
		send_item(MODE_PUT, 32'h5A5A_5A5A, -32'sd77);
		send_item(MODE_GET, 32'h5A5A_5A5A, 32'sd0);
	endtask

	task automatic test_capacity_edges();
		set_capacity(4'd15);
		for (int i = 0; i < 9; i++)
			send_item(MODE_PUT, 32'hC0DE_0000 + i * 32'h0101_0101, i * 32'sd1000 - 32'sd4000);
		set_capacity(4'd3);
		send_item(MODE_GET, 32'hC0DE_0000 + 4 * 32'h0101_0101, 32'sd0);
		send_item(MODE_PUT, 32'hDEAD_BEEF, 32'sd42);
		set_capacity(4'd8);
	endtask

	task automatic test_random_traffic(input int n_items, input logic [CAP_W-1:0] cap);
		int    pool_n;
		mode_t m;
		logic [KEY_W-1:0] k;
		set_capacity(cap);
		pool_n = effective_capacity() + 3;
		for (int i = 0; i < 16; i++)
			key_pool[i] = $urandom;
		for (int i = 0; i < n_items; i++) begin
			m = ($urandom_range(0, 99) < 45) ? MODE_PUT : MODE_GET;
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, pool_n - 1)];
			else
				k = $urandom;
			send_item(m, k, $urandom);
		end
	endtask

	task automatic test_backpressure();
		hold_toggle = ~hold_toggle;
		for (int i = 0; i < 40; i++)
			send_item(($urandom_range(0, 1) != 0) ? MODE_PUT : MODE_GET,
				32'h0000_0F00 | $urandom_range(0, 9), $urandom);
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			slot_key[i]   = '0;
			slot_value[i] = '0;
			slot_used[i]  = 1'b0;
			slot_age[i]   = 0;
		end
		used_count   = 0;
		capacity_reg = CAP_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_eviction();
		test_capacity_edges();

		send_idle_pct = 38;
		recv_idle_pct = 81;
		test_random_traffic(150, 4'd1);
		test_random_traffic(150, 4'd8);
		test_random_traffic(150, 4'd5);

		send_idle_pct = 81;
		recv_idle_pct = 38;
		test_random_traffic(150, 4'd0);
		test_random_traffic(150, 4'd15);
		test_random_traffic(150, 4'd3);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_traffic(150, 4'd8);
		test_random_traffic(150, 4'd2);
		test_random_traffic(150, 4'd6);

		in_valid <= 1'b0;
		while (cache_results_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d get/put items over capacities 0..15 under mixed stalls and a long hold.",
			items_sent);
		$display("Checked %0d results, %0d of them hits, with %0d mismatches.",
			results_seen, hits_seen, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
